// ----- rtl/aabb_pkg.sv -----
// ---------------------------------------------------------------------------
// aabb_pkg
// Shared types, codes and helpers for the box collision tester.
// ---------------------------------------------------------------------------
package aabb_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int VEC_W         = 32;
   localparam int WIDE_W        = 66;
   localparam int JOB_W         = 4;

   localparam logic [2:0] MODE_LOAD   = 3'd0;
   localparam logic [2:0] MODE_MOVE   = 3'd1;
   localparam logic [2:0] MODE_BOX    = 3'd2;
   localparam logic [2:0] MODE_SPHERE = 3'd3;
   localparam logic [2:0] MODE_PLANE  = 3'd4;

   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_MUL, ST_ACC, ST_DIST, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_DIV_GO, ST_DIV_WAIT, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_SQ_V, MUL_SQ_S, MUL_EXT, MUL_DOT, MUL_DIR
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_SUM, ACC_S2, ACC_R, ACC_DOT, ACC_DIR
   } acc_op_type;

   typedef struct packed {
      logic       load_req;
      logic       prep;
      logic       mul_go;
      mul_op_type mul_op;
      logic       acc_go;
      acc_op_type acc_op;
      logic [1:0] idx;
      logic       dist_go;
      logic       sqrt_go;
      logic       div_go;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       sqrt_done;
      logic       len_zero;
      logic       div_done;
      logic       out_free;
   } status_type;

   function automatic vec_type sat32(input wide_type v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[VEC_W-1:0];
   endfunction

endpackage

// ----- rtl/aabb_isqrt.sv -----
// ---------------------------------------------------------------------------
// aabb_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module aabb_isqrt import aabb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_comb begin
      n_in    = n_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_in   = n_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

// ----- rtl/aabb_div.sv -----
// ---------------------------------------------------------------------------
// aabb_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module aabb_div import aabb_pkg::*; #(
   parameter int DVD_W = VEC_W + FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [31:0]      divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [32:0]      trial;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/aabb_datapath.sv -----
// ---------------------------------------------------------------------------
// aabb_datapath
// Box state, operand registers, shared multiplier, accumulators, sqrt and
// divide units, and the result register.
// ---------------------------------------------------------------------------
module aabb_datapath import aabb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   output status_type   status,
   input  logic [223:0] req_tdata,
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata
);

   localparam int DVD_W = VEC_W + FRAC_BITS;

   logic [2:0]    mode_ff;
   vec_type       a_ff [3];
   vec_type       b_ff [3];
   vec_type       s_ff;
   vec_type       max_ff [3];
   vec_type       min_ff [3];
   vec_type       ctr_ff [3];
   vec_type       v_ff [3];
   vec_type       dir_ff [3];
   wide_type      prod_ff, acc_ff, dot_ff, s2_ff, dist_ff;
   logic          hit_ff, fault_ff, neg_ff;
   logic [1:0]    didx_ff;
   logic          rvalid_ff;
   logic [103:0]  rdata_ff;

   vec_type       gap [3];
   vec_type       offs [3];
   vec_type       ext [3];
   vec_type       sum_max [3];
   vec_type       sum_min [3];
   vec_type       sum_ctr [3];
   vec_type       mid [3];
   logic          hit2;
   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] a_i, dclip;
   wide_type      prod_sh, dist_diff;
   vec_type       numer;
   logic [31:0]   numer_mag;
   logic          sqrt_done, div_done;
   logic [31:0]   root;
   logic [DVD_W-1:0] quo;
   wide_type      quo_w;

   // per-axis combinational lanes
   always_comb begin
      logic signed [32:0] d1, d2, c, sm;
      hit2 = 1'b1;
      for (int i = 0; i < 3; i++) begin
         d1 = 33'(a_ff[i]) - 33'(min_ff[i]);
         d2 = 33'(max_ff[i]) - 33'(b_ff[i]);
         gap[i] = sat32(WIDE_W'((d1 > d2) ? d1 : d2));
         if (!(b_ff[i] <= max_ff[i] && a_ff[i] >= min_ff[i])) begin
            hit2 = 1'b0;
         end
         c = (a_ff[i] < max_ff[i]) ? 33'(a_ff[i]) : 33'(max_ff[i]);
         if (33'(min_ff[i]) > c) begin
            c = 33'(min_ff[i]);
         end
         offs[i] = sat32(WIDE_W'(c - 33'(a_ff[i])));
         ext[i]  = sat32(WIDE_W'(33'(max_ff[i]) - 33'(ctr_ff[i])));
         sum_max[i] = sat32(WIDE_W'(33'(max_ff[i]) + 33'(a_ff[i])));
         sum_min[i] = sat32(WIDE_W'(33'(min_ff[i]) + 33'(a_ff[i])));
         sum_ctr[i] = sat32(WIDE_W'(33'(ctr_ff[i]) + 33'(a_ff[i])));
         sm = 33'(a_ff[i]) + 33'(b_ff[i]);
         mid[i] = sm[32:1];
      end
   end

   // shared multiplier operand select
   assign a_i   = 33'(a_ff[cmd.idx]);
   assign dclip = (dist_ff > 66'sd2147483647) ? 33'sd2147483647 : dist_ff[32:0];

   always_comb begin
      mul_a = 33'(v_ff[cmd.idx]);
      mul_b = 33'(v_ff[cmd.idx]);
      case (cmd.mul_op)
         MUL_SQ_V: begin
            mul_a = 33'(v_ff[cmd.idx]);
            mul_b = 33'(v_ff[cmd.idx]);
         end
         MUL_SQ_S: begin
            mul_a = 33'(s_ff);
            mul_b = 33'(s_ff);
         end
         MUL_EXT: begin
            mul_a = 33'(v_ff[cmd.idx]);
            mul_b = (a_i < 0) ? -a_i : a_i;
         end
         MUL_DOT: begin
            mul_a = a_i;
            mul_b = 33'(ctr_ff[cmd.idx]);
         end
         MUL_DIR: begin
            mul_a = a_i;
            mul_b = dclip;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_sh   = prod_ff >>> FRAC_BITS;
   assign dist_diff = dot_ff - WIDE_W'(s_ff);

   // numerator for normalization: gap for box test, center offset for sphere
   assign numer     = (mode_ff == MODE_BOX) ? v_ff[cmd.idx]
                    : sat32(WIDE_W'(33'(a_ff[cmd.idx]) - 33'(ctr_ff[cmd.idx])));
   assign numer_mag = numer[VEC_W-1] ? 32'(-33'(numer)) : 32'(numer);

   aabb_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_go),
      .radicand (acc_ff[63:0]),
      .done     (sqrt_done),
      .root     (root)
   );

   aabb_div #(.DVD_W(DVD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend ({numer_mag, {FRAC_BITS{1'b0}}}),
      .divisor  (root),
      .done     (div_done),
      .quotient (quo)
   );

   assign quo_w = {{(WIDE_W-DVD_W){1'b0}}, quo};

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_tuser;
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= req_tdata[32*i +: 32];
            b_ff[i] <= req_tdata[96 + 32*i +: 32];
         end
         s_ff <= req_tdata[223:192];
      end
      if (cmd.prep) begin
         acc_ff   <= '0;
         dot_ff   <= '0;
         fault_ff <= 1'b0;
         hit_ff   <= (mode_ff == MODE_BOX) ? hit2 : 1'b0;
         for (int i = 0; i < 3; i++) begin
            dir_ff[i] <= '0;
            v_ff[i]   <= (mode_ff == MODE_BOX) ? gap[i]
                       : (mode_ff == MODE_SPHERE) ? offs[i] : ext[i];
         end
      end
      if (cmd.mul_go) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.acc_go) begin
         case (cmd.acc_op)
            ACC_SUM: acc_ff <= acc_ff + prod_ff;
            ACC_S2:  s2_ff  <= prod_ff;
            ACC_R:   acc_ff <= acc_ff + prod_sh;
            ACC_DOT: dot_ff <= dot_ff + prod_sh;
            ACC_DIR: dir_ff[cmd.idx] <= sat32(prod_sh);
            default: acc_ff <= acc_ff;
         endcase
      end
      if (cmd.dist_go) begin
         dist_ff <= (dist_diff < 0) ? -dist_diff : dist_diff;
         hit_ff  <= (((dist_diff < 0) ? -dist_diff : dist_diff) <= acc_ff);
      end
      // sphere hit: squared distance against squared radius; box hit stays
      if (cmd.sqrt_go && mode_ff == MODE_SPHERE) begin
         hit_ff <= (acc_ff[63:0] < s2_ff[63:0]);
      end
      if (sqrt_done && root == '0) begin
         fault_ff <= 1'b1;
      end
      if (cmd.div_go) begin
         neg_ff  <= numer[VEC_W-1];
         didx_ff <= cmd.idx;
      end
      if (div_done) begin
         dir_ff[didx_ff] <= sat32(neg_ff ? -quo_w : quo_w);
      end
      if (cmd.out_load) begin
         rdata_ff <= {6'd0, fault_ff, dir_ff[2], dir_ff[1], dir_ff[0], hit_ff};
      end
   end

   // box state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            max_ff[i] <= '0;
            min_ff[i] <= '0;
            ctr_ff[i] <= '0;
         end
      end else if (cmd.prep && mode_ff == MODE_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            max_ff[i] <= a_ff[i];
            min_ff[i] <= b_ff[i];
            ctr_ff[i] <= mid[i];
         end
      end else if (cmd.prep && mode_ff == MODE_MOVE) begin
         for (int i = 0; i < 3; i++) begin
            max_ff[i] <= sum_max[i];
            min_ff[i] <= sum_min[i];
            ctr_ff[i] <= sum_ctr[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rvalid_ff <= 1'b0;
      end
   end

   assign status.mode      = mode_ff;
   assign status.sqrt_done = sqrt_done;
   assign status.len_zero  = (root == '0);
   assign status.div_done  = div_done;
   assign status.out_free  = !rvalid_ff || rsp_tready;

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

endmodule

// ----- rtl/aabb_ctrl.sv -----
// ---------------------------------------------------------------------------
// aabb_ctrl
// Sequencer: steps the datapath through the job list of each mode.
// ---------------------------------------------------------------------------
module aabb_ctrl import aabb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [JOB_W-1:0] job_ff, job_in;
   mul_op_type       job_mul;
   acc_op_type       job_acc;
   logic [1:0]       job_idx;

   // job decode: mode and job number give the multiply and its use
   always_comb begin
      job_mul = MUL_SQ_V;
      job_acc = ACC_SUM;
      job_idx = job_ff[1:0];
      if (status.mode == MODE_PLANE) begin
         if (job_ff < 4'd3) begin
            job_mul = MUL_EXT;
            job_acc = ACC_R;
         end else if (job_ff < 4'd6) begin
            job_mul = MUL_DOT;
            job_acc = ACC_DOT;
            job_idx = 2'(job_ff - 4'd3);
         end else begin
            job_mul = MUL_DIR;
            job_acc = ACC_DIR;
            job_idx = 2'(job_ff - 4'd6);
         end
      end else if (job_ff == 4'd3) begin
         job_mul = MUL_SQ_S;
         job_acc = ACC_S2;
         job_idx = 2'd0;
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            job_in = '0;
            if (status.mode == MODE_BOX || status.mode == MODE_SPHERE ||
                status.mode == MODE_PLANE) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (status.mode == MODE_PLANE && job_ff == 4'd5) begin
               state_in = ST_DIST;
            end else if (status.mode == MODE_PLANE && job_ff == 4'd8) begin
               state_in = ST_DONE;
            end else if ((status.mode == MODE_BOX && job_ff == 4'd2) ||
                         (status.mode == MODE_SPHERE && job_ff == 4'd3)) begin
               state_in = ST_SQRT_GO;
            end else begin
               job_in   = job_ff + 4'd1;
               state_in = ST_MUL;
            end
         end
         ST_DIST: begin
            job_in   = job_ff + 4'd1;
            state_in = ST_MUL;
         end
         ST_SQRT_GO: state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: begin
            job_in = '0;
            if (status.sqrt_done) begin
               state_in = status.len_zero ? ST_DONE : ST_DIV_GO;
            end
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               if (job_ff == 4'd2) begin
                  state_in = ST_DONE;
               end else begin
                  job_in   = job_ff + 4'd1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.mul_op = job_mul;
      cmd.acc_op = job_acc;
      cmd.idx    = job_idx;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_PREP:     cmd.prep    = 1'b1;
         ST_MUL:      cmd.mul_go  = 1'b1;
         ST_ACC:      cmd.acc_go  = 1'b1;
         ST_DIST:     cmd.dist_go = 1'b1;
         ST_SQRT_GO:  cmd.sqrt_go = 1'b1;
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            cmd.idx    = job_ff[1:0];
         end
         ST_DONE:     cmd.out_load = status.out_free;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/aabb_collision_tester.sv -----
// ---------------------------------------------------------------------------
// aabb_collision_tester
// Axis-aligned box holder with box, sphere and plane intersection tests.
// ---------------------------------------------------------------------------
// Use: each request on the req_ channel carries a mode in req_tuser and
// the operands in req_tdata. Load and translate update the held box;
// box, sphere and plane tests return a hit flag and a Q-format direction
// on the rsp_ channel. Every request gives exactly one response.
// Load, translate and unused modes pass through the prep and done states;
// the response turns valid once the done state loads the output register.
// A plane test runs nine multiply/accumulate pairs on one shared
// multiplier. In box and sphere tests the 32-step square root and three
// restoring divisions, one quotient bit a cycle, dominate.
// One request is in flight at a time; the next is taken once the result
// is handed to the output register, so a waiting result does not block.
// Reset clears the box to zero and empties the output register.
// When the receiver stalls, the result holds in rsp_tdata and the block
// waits in its final step until the output register frees.
// ---------------------------------------------------------------------------
module aabb_collision_tester import aabb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar_s
   input  logic [223:0] req_tdata,
   // mode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit, dir_x, dir_y, dir_z, div_fault, zero pad
   output logic [103:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   aabb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   aabb_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- tb/sv/tb_aabb_collision_tester.sv -----
// ---------------------------------------------------------------------------
// tb_aabb_collision_tester
// Self-checking bench for the box collision tester: a queue-fed driver
// streams load, translate, box, sphere, plane and undefined-mode requests,
// a scoreboard predicts each response bit for bit and a monitor compares.
// ---------------------------------------------------------------------------
module tb_aabb_collision_tester import aabb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  F          = 16;
   localparam int  WDOG_LIMIT = 6000;     // idle cycles; above the slowest test plus the long hold-off
   localparam int  HOLD_LEN   = 600;      // long receiver stall to back up the input

   typedef struct packed {
      logic [2:0] mode;
      vec_type    ax, ay, az, bx, by, bz, s;
   } req_item_type;

   typedef struct packed {
      logic    hit;
      vec_type dx, dy, dz;
      logic    fault;
   } contact_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar_s
   logic [223:0] req_tdata = '0;
   // mode
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // hit, dir_x, dir_y, dir_z, div_fault, zero pad
   logic [103:0] rsp_tdata;

   aabb_collision_tester #(.FRAC_BITS(F)) dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // ---- predictor state: the box as the block should hold it
   longint       hold_max[3], hold_min[3], hold_ctr[3];
   req_item_type pending_reqs[$];
   contact_type  expected_contacts[$];
   int           errors = 0;
   int           n_sent = 0, n_seen = 0, n_hits = 0, n_faults = 0;
   int           mode_count[8];

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned mag_sq(longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   // bit-by-bit integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Applies one accepted request to the box copy and queues its response.
   function automatic void predict_contact(req_item_type it);
      longint          a[3], b[3], dir[3], gap[3], s, len, d1, d2, c, r, dot;
      longint          plane_dist, dclip;
      longint unsigned sum;
      contact_type     e;
      int              i;
      a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
      b[0] = it.bx; b[1] = it.by; b[2] = it.bz;
      s = it.s;
      dir = '{0, 0, 0};
      e = '0;
      mode_count[it.mode]++;
      case (it.mode)
         MODE_LOAD: begin
            for (i = 0; i < 3; i++) begin
               hold_max[i] = a[i];
               hold_min[i] = b[i];
               hold_ctr[i] = (a[i] + b[i]) >>> 1;
            end
         end
         MODE_MOVE: begin
            for (i = 0; i < 3; i++) begin
               hold_max[i] = clip32(hold_max[i] + a[i]);
               hold_min[i] = clip32(hold_min[i] + a[i]);
               hold_ctr[i] = clip32(hold_ctr[i] + a[i]);
            end
         end
         MODE_BOX: begin
            e.hit = 1'b1;
            sum = 0;
            for (i = 0; i < 3; i++) begin
               d1 = a[i] - hold_min[i];
               d2 = hold_max[i] - b[i];
               gap[i] = clip32(d1 > d2 ? d1 : d2);
               sum += mag_sq(gap[i]);
               if (!(b[i] <= hold_max[i] && a[i] >= hold_min[i])) e.hit = 1'b0;
            end
            len = int_sqrt(sum);
            if (len == 0) e.fault = 1'b1;
            else for (i = 0; i < 3; i++) dir[i] = clip32((gap[i] <<< F) / len);
         end
         MODE_SPHERE: begin
            sum = 0;
            for (i = 0; i < 3; i++) begin
               c = (a[i] < hold_max[i]) ? a[i] : hold_max[i];
               if (hold_min[i] > c) c = hold_min[i];
               sum += mag_sq(clip32(c - a[i]));
            end
            e.hit = sum < mag_sq(s);
            len = int_sqrt(sum);
            if (len == 0) e.fault = 1'b1;
            else for (i = 0; i < 3; i++)
               dir[i] = clip32((clip32(a[i] - hold_ctr[i]) <<< F) / len);
         end
         MODE_PLANE: begin
            r = 0;
            dot = 0;
            for (i = 0; i < 3; i++) begin
               r += (clip32(hold_max[i] - hold_ctr[i]) * (a[i] < 0 ? -a[i] : a[i])) >>> F;
               dot += (a[i] * hold_ctr[i]) >>> F;
            end
            plane_dist = dot - s;
            if (plane_dist < 0) plane_dist = -plane_dist;
            e.hit = plane_dist <= r;
            dclip = (plane_dist > 64'sd2147483647) ? 64'sd2147483647 : plane_dist;
            for (i = 0; i < 3; i++) dir[i] = clip32((a[i] * dclip) >>> F);
         end
         default: ;   // undefined modes: box untouched, all-zero response
      endcase
      e.dx = dir[0][31:0];
      e.dy = dir[1][31:0];
      e.dz = dir[2][31:0];
      if (e.hit) n_hits++;
      if (e.fault) n_faults++;
      expected_contacts.push_back(e);
   endfunction

   // ---- driver: one request from the pending queue at a time
   int gap_left = 0;
   int acc_cycle_idle = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         predict_contact({req_tuser, req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                          req_tdata[127:96], req_tdata[159:128], req_tdata[191:160],
                          req_tdata[223:192]});
         n_sent++;
         if (gap_left == 0 && pending_reqs.size() > 0) begin
            drive_next();
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (pending_reqs.size() > 0) drive_next();
      end
   end

   task automatic drive_next();
      req_item_type it;
      it = pending_reqs.pop_front();
      req_tvalid <= 1'b1;
      req_tuser  <= it.mode;
      req_tdata  <= {it.s, it.bz, it.by, it.bx, it.az, it.ay, it.ax};
      // bursts with no gaps on a part of the run
      gap_left   <= ((n_sent % 200) < 40) ? 0 : $urandom_range(0, 7);
   endtask

   // ---- monitor: receiver stalls, one long hold-off, compare
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            check_contact();
            n_seen++;
            stall_left <= ((n_seen % 160) < 30) ? 0 : $urandom_range(0, 7);
         end
         if (!hold_done && n_seen == 100) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0 && !(rsp_tvalid && rsp_tready)) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_tvalid && rsp_tready) || stall_left == 0;
         end
      end
   end

   task automatic check_contact();
      contact_type e, got;
      got = {rsp_tdata[0], rsp_tdata[32:1], rsp_tdata[64:33], rsp_tdata[96:65],
             rsp_tdata[97]};
      if (expected_contacts.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         errors++;
      end else begin
         e = expected_contacts.pop_front();
         if (got.hit !== e.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.hit, got.hit); errors++;
         end
         if (got.dx !== e.dx) begin
            $display("%0t: dir_x exp %h got %h", $time, e.dx, got.dx); errors++;
         end
         if (got.dy !== e.dy) begin
            $display("%0t: dir_y exp %h got %h", $time, e.dy, got.dy); errors++;
         end
         if (got.dz !== e.dz) begin
            $display("%0t: dir_z exp %h got %h", $time, e.dz, got.dz); errors++;
         end
         if (got.fault !== e.fault) begin
            $display("%0t: div_fault exp %0d got %0d", $time, e.fault, got.fault);
            errors++;
         end
      end
   endtask

   // ---- watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         acc_cycle_idle <= 0;
      end else begin
         acc_cycle_idle <= acc_cycle_idle + 1;
         if (acc_cycle_idle >= WDOG_LIMIT) begin
            $display("%0t: watchdog, no progress", $time);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---- stimulus
   function automatic vec_type rand_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7fffffff;
               1:       return 32'sh80000000;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      endcase
   endfunction

   function automatic req_item_type make_req(logic [2:0] m);
      req_item_type it;
      it.mode = m;
      it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
      it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
      it.s  = rand_coord();
      if (m == MODE_LOAD || m == MODE_BOX) begin
         // mostly well-ordered corners so hits and misses both occur
         if ($urandom_range(0, 3) != 0) begin
            if (it.ax < it.bx) {it.ax, it.bx} = {it.bx, it.ax};
            if (it.ay < it.by) {it.ay, it.by} = {it.by, it.ay};
            if (it.az < it.bz) {it.az, it.bz} = {it.bz, it.az};
         end
      end
      if (m == MODE_SPHERE && $urandom_range(0, 2) != 0)
         it.s = $urandom_range(0, 32'h1fffff);
      if (m == MODE_MOVE && $urandom_range(0, 3) != 0) begin
         it.ax = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         it.ay = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         it.az = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      end
      return it;
   endfunction

   function automatic req_item_type fixed_req(logic [2:0] m, vec_type a, vec_type b,
                                              vec_type s);
      return '{mode: m, ax: a, ay: a, az: a, bx: b, by: b, bz: b, s: s};
   endfunction

   initial begin
      int k, w;
      logic [2:0] m;
      // directed: extremes, zero divisors, saturation, undefined modes
      pending_reqs.push_back(fixed_req(MODE_BOX, 0, 0, 0));             // reset box, zero gap
      pending_reqs.push_back(fixed_req(MODE_SPHERE, 0, 0, 32'sd1));     // center inside, len 0
      pending_reqs.push_back(fixed_req(MODE_PLANE, 32'sh10000, 0, 0));
      pending_reqs.push_back(fixed_req(MODE_LOAD, 32'sh7fffffff, 32'sh80000000, 0));
      pending_reqs.push_back(fixed_req(MODE_BOX, 32'sh7fffffff, 32'sh80000000, 0));
      pending_reqs.push_back(fixed_req(MODE_BOX, 32'sh80000000, 32'sh7fffffff, 0));
      pending_reqs.push_back(fixed_req(MODE_SPHERE, 32'sh7fffffff, 0, 32'sh80000000));
      pending_reqs.push_back(fixed_req(MODE_PLANE, 32'sh80000000, 0, 32'sh7fffffff));
      pending_reqs.push_back(fixed_req(MODE_PLANE, 32'sh7fffffff, 0, 32'sh80000000));
      pending_reqs.push_back(fixed_req(MODE_MOVE, 32'sh7fffffff, 0, 0)); // saturate up
      pending_reqs.push_back(fixed_req(MODE_SPHERE, 32'sh80000000, 0, 32'sh7fffffff));
      pending_reqs.push_back(fixed_req(MODE_MOVE, 32'sh80000000, 0, 0)); // saturate down
      pending_reqs.push_back(fixed_req(MODE_MOVE, 32'sh80000000, 0, 0));
      pending_reqs.push_back(fixed_req(MODE_BOX, 32'sh7fffffff, 32'sh80000000, 0));
      pending_reqs.push_back(fixed_req(MODE_LOAD, 32'sh30000, -32'sh30000, 0));
      pending_reqs.push_back(fixed_req(MODE_SPHERE, 32'sh50000, 0, 32'sh20001));
      pending_reqs.push_back(fixed_req(MODE_SPHERE, 32'sh50000, 0, 32'sh20000));
      pending_reqs.push_back(fixed_req(MODE_BOX, 32'sh10000, -32'sh10000, 0));
      pending_reqs.push_back(fixed_req(MODE_PLANE, 32'sh10000, 0, 32'sh30000));
      pending_reqs.push_back(fixed_req(3'd5, 32'sh7fffffff, -1, -1));
      pending_reqs.push_back(fixed_req(3'd6, -1, 32'sh7fffffff, 0));
      pending_reqs.push_back(fixed_req(3'd7, 32'sh80000000, 32'sh80000000, 32'sh7fffffff));
      // random: well-formed box traffic with occasional undefined modes
      for (k = 0; k < 630; k++) begin
         w = $urandom_range(0, 99);
         if (w < 15)      m = MODE_LOAD;
         else if (w < 25) m = MODE_MOVE;
         else if (w < 50) m = MODE_BOX;
         else if (w < 75) m = MODE_SPHERE;
         else if (w < 95) m = MODE_PLANE;
         else             m = $urandom_range(5, 7);
         pending_reqs.push_back(make_req(m));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_tvalid && expected_contacts.size() == 0);
      repeat (300) @(posedge clock);

      if (expected_contacts.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_contacts.size());
         errors++;
      end
      $display("Covered %0d requests: load %0d, move %0d, box %0d, sphere %0d, plane %0d",
               n_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
               mode_count[4]);
      $display("undefined %0d, hits %0d, zero-divisor faults %0d, %0d mismatches",
               mode_count[5] + mode_count[6] + mode_count[7], n_hits, n_faults, errors);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
